@@ rtl/core/rcpc_pkg.sv @@
package rcpc_pkg;

   localparam int PACKET_BYTES = 29;

   localparam int COUNT_WIDTH = 6;
   localparam int ID_WIDTH = 24;
   localparam int TICK_WIDTH = 16;
   localparam int CSR_DATA_WIDTH = 24;
   localparam int CSR_INDEX_WIDTH = 1;

   localparam logic [COUNT_WIDTH-1:0] PACKET_COUNT = COUNT_WIDTH'(PACKET_BYTES);
   localparam logic [COUNT_WIDTH-1:0] LAST_BYTE = COUNT_WIDTH'(PACKET_BYTES - 1);
   localparam logic [COUNT_WIDTH-1:0] ID_FIRST = 6'd17;
   localparam logic [COUNT_WIDTH-1:0] ID_MIDDLE = 6'd18;
   localparam logic [COUNT_WIDTH-1:0] ID_LAST = 6'd19;
   localparam logic [COUNT_WIDTH-1:0] CMD_BYTE = 6'd22;
   localparam logic [COUNT_WIDTH-1:0] SEQ_BYTE = 6'd23;
   localparam logic [COUNT_WIDTH-1:0] SUM_LAST = 6'd25;
   localparam logic [COUNT_WIDTH-1:0] CHECK_BYTE = 6'd26;

   localparam logic [7:0] CMD_CLEAR = 8'h01;
   localparam logic [7:0] CMD_SET = 8'h02;
   localparam logic [7:0] CMD_TOGGLE = 8'h04;

   localparam logic [ID_WIDTH-1:0] DEVICE_ID_RESET = 24'h111111;
   localparam logic [TICK_WIDTH-1:0] TIMEOUT_RESET = 16'd4000;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_DEVICE_ID = 1'b0,
      CSR_TIMEOUT_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic {
      ITEM_BYTE = 1'b0,
      ITEM_TICK = 1'b1
   } item_kind_type;

   typedef struct packed {
      logic command;
      logic start_of_packet;
      logic [7:0] packet_byte;
   } req_payload_type;

   typedef struct packed {
      logic led_on;
      logic link_mode;
      logic id_matched;
      logic packet_accepted;
   } rsp_payload_type;

endpackage

@@ rtl/core/radio_command_packet_checker.sv @@
// Checks received advertising packets byte by byte and acts on the LED command they carry;
// timer ticks on the same channel age the receive link back to scan mode. Every transfer on
// req gives exactly one transfer on rsp. An item is captured in the input register and its
// result is registered in the output register, and one item is taken every cycle while rsp
// is not stalled; the compare, add and LED update logic sits between the two registers.
// Write device_id and timeout_limit only while no transfers are in flight.
module radio_command_packet_checker
   import rcpc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  req_payload_type req_payload,
   output logic rsp_valid,
   input  logic rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_data
);

   logic hold_valid_ff;
   req_payload_type hold_ff;
   logic rsp_valid_ff;
   rsp_payload_type rsp_ff;

   logic [ID_WIDTH-1:0] device_id_ff;
   logic [TICK_WIDTH-1:0] timeout_limit_ff;

   logic [COUNT_WIDTH-1:0] byte_count_ff, byte_count_in;
   logic id_good_ff, id_good_in;
   logic [7:0] running_sum_ff, running_sum_in;
   logic [7:0] held_command_ff, held_command_in;
   logic [7:0] held_sequence_ff, held_sequence_in;
   logic [7:0] last_sequence_ff, last_sequence_in;
   logic led_level_ff, led_level_in;
   logic mode_ff, mode_in;
   logic [TICK_WIDTH-1:0] tick_count_ff, tick_count_in;

   logic out_free;
   logic fire;
   logic judge;
   logic matched;
   logic accepted;
   logic [COUNT_WIDTH-1:0] idx;
   logic id_cur;
   logic [7:0] sum_cur;
   logic [7:0] id_byte;
   logic [TICK_WIDTH-1:0] tick_next;
   rsp_payload_type rsp_in;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign fire = hold_valid_ff && out_free;
   assign req_stall = hold_valid_ff && !out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      byte_count_in = byte_count_ff;
      id_good_in = id_good_ff;
      running_sum_in = running_sum_ff;
      held_command_in = held_command_ff;
      held_sequence_in = held_sequence_ff;
      last_sequence_in = last_sequence_ff;
      led_level_in = led_level_ff;
      mode_in = mode_ff;
      tick_count_in = tick_count_ff;
      matched = 1'b0;
      accepted = 1'b0;
      judge = 1'b0;
      id_byte = device_id_ff[7:0];
      tick_next = tick_count_ff + 1'b1;

      idx = hold_ff.start_of_packet ? '0 : byte_count_ff;
      id_cur = hold_ff.start_of_packet ? 1'b1 : id_good_ff;
      sum_cur = hold_ff.start_of_packet ? 8'h00 : running_sum_ff;

      if (idx == ID_FIRST) begin
         id_byte = device_id_ff[23:16];
      end else if (idx == ID_MIDDLE) begin
         id_byte = device_id_ff[15:8];
      end

      if (item_kind_type'(hold_ff.command) == ITEM_TICK) begin
         tick_count_in = tick_next;
         if (tick_next > timeout_limit_ff) begin
            tick_count_in = '0;
            mode_in = 1'b0;
         end
      end else if (hold_ff.start_of_packet || byte_count_ff < PACKET_COUNT) begin
         byte_count_in = idx;
         id_good_in = id_cur;
         running_sum_in = sum_cur;
         if (idx < PACKET_COUNT) begin
            if (idx >= ID_FIRST && idx <= ID_LAST && id_byte != hold_ff.packet_byte) begin
               id_good_in = 1'b0;
            end
            if (idx >= ID_FIRST && idx <= SUM_LAST) begin
               running_sum_in = sum_cur + hold_ff.packet_byte;
            end
            if (idx == CHECK_BYTE) begin
               running_sum_in = sum_cur ^ hold_ff.packet_byte;
            end
            if (idx == CMD_BYTE) begin
               held_command_in = hold_ff.packet_byte;
            end
            if (idx == SEQ_BYTE) begin
               held_sequence_in = hold_ff.packet_byte;
            end
            byte_count_in = idx + 1'b1;
            judge = (idx == LAST_BYTE);
         end
      end

      if (judge) begin
         matched = id_good_in;
         if (id_good_in) begin
            mode_in = 1'b1;
            tick_count_in = '0;
            if (running_sum_in == 8'h00) begin
               accepted = 1'b1;
               case (held_command_in)
                  CMD_SET: led_level_in = 1'b1;
                  CMD_CLEAR: led_level_in = 1'b0;
                  CMD_TOGGLE: begin
                     if (last_sequence_ff != held_sequence_in) begin
                        led_level_in = !led_level_ff;
                     end
                  end
                  default: led_level_in = led_level_ff;
               endcase
               last_sequence_in = held_sequence_in;
            end
         end
      end

      rsp_in.led_on = led_level_in;
      rsp_in.link_mode = mode_in;
      rsp_in.id_matched = matched;
      rsp_in.packet_accepted = accepted;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         device_id_ff <= DEVICE_ID_RESET;
         timeout_limit_ff <= TIMEOUT_RESET;
         byte_count_ff <= '0;
         id_good_ff <= 1'b1;
         running_sum_ff <= '0;
         held_command_ff <= '0;
         held_sequence_ff <= '0;
         last_sequence_ff <= '0;
         led_level_ff <= 1'b0;
         mode_ff <= 1'b0;
         tick_count_ff <= '0;
      end else begin
         if (!req_stall) begin
            hold_valid_ff <= req_valid;
         end
         if (out_free) begin
            rsp_valid_ff <= hold_valid_ff;
         end
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_DEVICE_ID: device_id_ff <= csr_data[ID_WIDTH-1:0];
               CSR_TIMEOUT_LIMIT: timeout_limit_ff <= csr_data[TICK_WIDTH-1:0];
               default: device_id_ff <= device_id_ff;
            endcase
         end
         if (fire) begin
            byte_count_ff <= byte_count_in;
            id_good_ff <= id_good_in;
            running_sum_ff <= running_sum_in;
            held_command_ff <= held_command_in;
            held_sequence_ff <= held_sequence_in;
            last_sequence_ff <= last_sequence_in;
            led_level_ff <= led_level_in;
            mode_ff <= mode_in;
            tick_count_ff <= tick_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         hold_ff <= req_payload;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.packet_accepted |-> rsp_ff.id_matched)
      else $error("packet accepted without an ID match");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.id_matched |-> rsp_ff.link_mode)
      else $error("ID matched but link not in receive mode");

   assert property (@(posedge clock) disable iff (reset)
      byte_count_ff <= PACKET_COUNT)
      else $error("byte count ran past the packet length");

   assert property (@(posedge clock) disable iff (reset)
      fire && matched |=> tick_count_ff == '0 && mode_ff)
      else $error("ID match did not clear the tick count");

   assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff && !out_free |=> hold_valid_ff && $stable(hold_ff))
      else $error("held item lost while the output was stalled");
`endif

endmodule
